[rtl/core/i2cm_pkg.sv]
// Shared types and constants for the I2C master byte engine.
// No dependencies; every other file of the block but the checker refers to it by scoped names.
`default_nettype none
package i2cm_pkg;

  // command codes carried in the action field
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_ACK   = 3'd5;
  localparam logic [2:0] ACT_NAK   = 3'd6;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_POLL    = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_POLL_RST    = 8'd50;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/i2cm_cfg_regs.sv]
// Configuration registers of the I2C master byte engine: unit length and ACK poll limit.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output logic [15:0]      phase_ticks,
  output logic [7:0]       ack_poll_limit
);

  logic [15:0] phase_ticks_r;
  logic [7:0]  ack_poll_r;

  assign cfg_ready      = 1'b1;
  assign phase_ticks    = phase_ticks_r;
  assign ack_poll_limit = ack_poll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
      ack_poll_r    <= i2cm_pkg::ACK_POLL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        i2cm_pkg::CFG_ACK_POLL:    ack_poll_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2cm_in_stage.sv]
// Input register of the I2C master byte engine: holds one tick word until the engine takes it.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire i2cm_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 s1_valid,
  output i2cm_pkg::item_t      s1_item
);

  logic            valid_r;
  i2cm_pkg::item_t item_r;
  logic            load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2cm_engine.sv]
// Line sequencer of the I2C master byte engine: advances the bus state by one tick per word
// and registers the resulting line levels. Depends on i2cm_pkg.
`default_nettype none
module i2cm_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s1_valid,
  input  wire i2cm_pkg::item_t s1_item,
  output logic                 advance,
  input  wire logic [15:0]     phase_ticks,
  input  wire logic [7:0]      ack_poll_limit,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output i2cm_pkg::result_t    out_result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_START = 4'd1,
    ST_STOP  = 4'd2,
    ST_WBIT  = 4'd3,
    ST_ACKW  = 4'd4,
    ST_RBIT  = 4'd5,
    ST_MACK  = 4'd6
  } state_t;

  state_t            state_r, state_nxt;
  logic [15:0]       pc_r, pc_nxt;
  logic [1:0]        uc_r, uc_nxt;
  logic [1:0]        pstep_r, pstep_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        poll_r, poll_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              drv_r, drv_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        rbyte_r, rbyte_nxt;
  logic              done_nxt;
  logic              out_valid_r;
  i2cm_pkg::result_t result_r, result_nxt;

  logic [16:0] pc_inc;
  logic [15:0] period;
  logic [1:0]  uc_inc;
  logic [1:0]  units_max;
  logic [3:0]  bit_inc;

  assign advance    = s1_valid && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_result = result_r;
  assign period     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    uc_nxt    = uc_r;
    pstep_nxt = pstep_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    ack_nxt   = ack_r;
    rbyte_nxt = rbyte_r;
    done_nxt  = 1'b0;
    pc_inc    = 17'd0;
    uc_inc    = 2'd0;
    units_max = 2'd1;
    bit_inc   = 4'd0;

    // take a command only while idle
    if (state_r == ST_IDLE && s1_item.action >= i2cm_pkg::ACT_START &&
        s1_item.action <= i2cm_pkg::ACT_NAK) begin
      pc_nxt    = 16'd0;
      uc_nxt    = 2'd0;
      pstep_nxt = 2'd0;
      bit_nxt   = 4'd0;
      poll_nxt  = 8'd0;
      unique case (s1_item.action)
        i2cm_pkg::ACT_START: begin
          state_nxt = ST_START; drv_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
        end
        i2cm_pkg::ACT_STOP: begin
          state_nxt = ST_STOP; drv_nxt = 1'b1; sda_nxt = 1'b0; scl_nxt = 1'b1;
        end
        i2cm_pkg::ACT_WRITE: begin
          state_nxt = ST_WBIT; drv_nxt = 1'b1;
          sda_nxt   = s1_item.write_data[7];
          shift_nxt = {s1_item.write_data[6:0], 1'b0};
        end
        i2cm_pkg::ACT_READ: begin
          state_nxt = ST_RBIT; drv_nxt = 1'b0; shift_nxt = 8'd0;
        end
        default: begin
          state_nxt = ST_MACK; drv_nxt = 1'b1;
          sda_nxt   = (s1_item.action == i2cm_pkg::ACT_NAK);
        end
      endcase
    end

    if (state_nxt != ST_IDLE) begin
      units_max = (state_nxt == ST_START || state_nxt == ST_STOP) ? 2'd3 : 2'd1;
      pc_inc    = {1'b0, pc_nxt} + 17'd1;
      if (pc_inc < {1'b0, period}) begin
        pc_nxt = pc_inc[15:0];
      end else begin
        pc_nxt = 16'd0;
        uc_inc = uc_nxt + 2'd1;
        if (uc_inc < units_max) begin
          uc_nxt = uc_inc;
        end else begin
          uc_nxt  = 2'd0;
          bit_inc = bit_nxt + 4'd1;
          // end of phase: move the lines to the next step
          unique case (state_nxt)
            ST_START: begin
              if (pstep_nxt == 2'd0) begin
                sda_nxt = 1'b0; pstep_nxt = 2'd1;
              end else if (pstep_nxt == 2'd1) begin
                scl_nxt = 1'b0; pstep_nxt = 2'd2;
              end else begin
                state_nxt = ST_IDLE; pstep_nxt = 2'd0; done_nxt = 1'b1;
              end
            end
            ST_STOP: begin
              if (pstep_nxt == 2'd0) begin
                sda_nxt = 1'b1; pstep_nxt = 2'd1;
              end else begin
                drv_nxt = 1'b0;
                state_nxt = ST_IDLE; pstep_nxt = 2'd0; done_nxt = 1'b1;
              end
            end
            ST_WBIT: begin
              if (pstep_nxt == 2'd0) begin
                scl_nxt = 1'b1; pstep_nxt = 2'd1;
              end else if (pstep_nxt == 2'd1) begin
                scl_nxt = 1'b0; pstep_nxt = 2'd2;
              end else begin
                bit_nxt   = bit_inc;
                pstep_nxt = 2'd0;
                if (bit_inc >= 4'd8) begin
                  state_nxt = ST_ACKW; drv_nxt = 1'b0; sda_nxt = 1'b1; poll_nxt = 8'd0;
                end else begin
                  sda_nxt   = shift_nxt[7];
                  shift_nxt = {shift_nxt[6:0], 1'b0};
                end
              end
            end
            ST_ACKW: begin
              if (pstep_nxt == 2'd0) begin
                scl_nxt = 1'b1; pstep_nxt = 2'd1;
              end else if (pstep_nxt == 2'd1) begin
                // give up once the poll budget is spent, else look for SDA low
                if (poll_nxt >= ack_poll_limit) begin
                  ack_nxt = 1'b0; scl_nxt = 1'b0; pstep_nxt = 2'd2;
                end else if (!s1_item.sda_in) begin
                  ack_nxt = 1'b1; scl_nxt = 1'b0; pstep_nxt = 2'd2;
                end else begin
                  poll_nxt = poll_nxt + 8'd1;
                end
              end else begin
                drv_nxt = 1'b1; sda_nxt = 1'b1;
                state_nxt = ST_IDLE; pstep_nxt = 2'd0; done_nxt = 1'b1;
              end
            end
            ST_RBIT: begin
              if (pstep_nxt == 2'd0) begin
                scl_nxt = 1'b1; pstep_nxt = 2'd1;
              end else if (pstep_nxt == 2'd1) begin
                shift_nxt = {shift_nxt[6:0], s1_item.sda_in};
                scl_nxt   = 1'b0; pstep_nxt = 2'd2;
              end else begin
                bit_nxt   = bit_inc;
                pstep_nxt = 2'd0;
                if (bit_inc >= 4'd8) begin
                  rbyte_nxt = shift_nxt;
                  state_nxt = ST_IDLE; done_nxt = 1'b1;
                end
              end
            end
            ST_MACK: begin
              if (pstep_nxt == 2'd0) begin
                scl_nxt = 1'b1; pstep_nxt = 2'd1;
              end else if (pstep_nxt == 2'd1) begin
                scl_nxt = 1'b0; pstep_nxt = 2'd2;
              end else begin
                state_nxt = ST_IDLE; pstep_nxt = 2'd0; done_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = ST_IDLE; pstep_nxt = 2'd0; done_nxt = 1'b1;
            end
          endcase
        end
      end
    end

    result_nxt.scl_level = scl_nxt;
    result_nxt.sda_level = sda_nxt;
    result_nxt.sda_drive = drv_nxt;
    result_nxt.busy_res  = (state_nxt != ST_IDLE);
    result_nxt.done_res  = done_nxt;
    result_nxt.read_data = rbyte_nxt;
    result_nxt.ack_seen  = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= 16'd0;
      uc_r        <= 2'd0;
      pstep_r     <= 2'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      poll_r      <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b0;
      ack_r       <= 1'b0;
      rbyte_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r  <= state_nxt;
        pc_r     <= pc_nxt;
        uc_r     <= uc_nxt;
        pstep_r  <= pstep_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        poll_r   <= poll_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        drv_r    <= drv_nxt;
        ack_r    <= ack_nxt;
        rbyte_r  <= rbyte_nxt;
        result_r <= result_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: configuration registers, input register and
// line sequencer. Depends on i2cm_pkg, i2cm_cfg_regs, i2cm_in_stage and i2cm_engine.
//
// Usage:
//   Each input word is one bus tick, carrying an optional command (start, stop, write byte,
//   read byte, send ACK, send NAK), the byte to write and the sampled SDA level. Commands
//   offered while a command is running are ignored. Every input word yields exactly one
//   result word with the SCL/SDA levels, SDA drive enable, busy, done pulse, last read byte
//   and last ACK status, all taken after that tick.
//   The configuration port sets the ticks per phase unit and the ACK poll limit; write it
//   only while the engine is idle. cfg_ready is always high.
//   A word accepted into the input register is processed by the registered next-state pass
//   and its result is offered from the result register. Throughput: one word per cycle,
//   set by that single pass from the input register, while the result side does not stall.
//   When the result side stalls, the result holds, the input register keeps one word and
//   in_stall rises until the result is taken.
//   Reset: synchronous; the bus idles with SCL and SDA high, SDA released, no word held,
//   ticks per unit 100 and ACK poll limit 50.
`default_nettype none
module i2c_master_byte_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_level,
  output logic             out_sda_level,
  output logic             out_sda_drive,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_data,
  output logic             out_ack_seen,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic              [15:0] phase_ticks;
  logic              [7:0]  ack_poll_limit;
  i2cm_pkg::item_t          in_item;
  i2cm_pkg::item_t          s1_item;
  logic                     s1_valid;
  logic                     advance;
  i2cm_pkg::result_t        result;

  assign in_item.action     = in_action;
  assign in_item.write_data = in_write_data;
  assign in_item.sda_in     = in_sda_in;

  i2cm_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .phase_ticks    (phase_ticks),
    .ack_poll_limit (ack_poll_limit)
  );

  i2cm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  i2cm_engine u_eng (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .advance        (advance),
    .phase_ticks    (phase_ticks),
    .ack_poll_limit (ack_poll_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result     (result)
  );

  assign out_scl_level = result.scl_level;
  assign out_sda_level = result.sda_level;
  assign out_sda_drive = result.sda_drive;
  assign out_busy_res  = result.busy_res;
  assign out_done_res  = result.done_res;
  assign out_read_data = result.read_data;
  assign out_ack_seen  = result.ack_seen;

endmodule
`default_nettype wire

[rtl/core/i2cm_checker.sv]
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_scl_level,
  input wire logic       out_sda_level,
  input wire logic       out_sda_drive,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic [7:0] out_read_data,
  input wire logic       out_ack_seen
);

  // a finishing word never also reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_busy_res))
    else $error("done and busy reported together");

  // reset drops any held result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // an accepted input word is followed by a result word on offer
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted word produced no result");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl_level) &&
      $stable(out_sda_level) && $stable(out_sda_drive) && $stable(out_busy_res) &&
      $stable(out_done_res) && $stable(out_read_data) && $stable(out_ack_seen))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_scl_level (out_scl_level),
  .out_sda_level (out_sda_level),
  .out_sda_drive (out_sda_drive),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_data (out_read_data),
  .out_ack_seen  (out_ack_seen)
);
`default_nettype wire
